// ----- hw/rtl/chm_pkg.sv -----
// ----------------------------------------------------------------------------
// chm_pkg
// Shared constants and helpers for the chained hash id map.
// ----------------------------------------------------------------------------
package chm_pkg;
    localparam int TABLE_BITS   = 8;
    localparam int POOL_ENTRIES = 256;
    localparam int NBUCKETS     = 1 << TABLE_BITS;
    localparam int IDX_W        = $clog2(POOL_ENTRIES + 1);
    localparam int SLOT_W       = $clog2(POOL_ENTRIES);
    localparam int KEY_W        = 64;
    localparam int VAL_W        = 32;
    localparam int CNT_W        = 9;

    localparam logic [IDX_W-1:0] NULL_IDX = IDX_W'(POOL_ENTRIES);

    typedef logic [1:0] action_t;
    localparam action_t ACT_INSERT = 2'd0;
    localparam action_t ACT_LOOKUP = 2'd1;
    localparam action_t ACT_REMOVE = 2'd2;

    function automatic logic [TABLE_BITS-1:0] mix_bucket(input logic [63:0] h);
        logic [63:0] m;
        begin
            m = (h << 7) - h + (h >> 9) + (h >> 17);
            mix_bucket = m[TABLE_BITS-1:0];
        end
    endfunction
endpackage

// ----- hw/rtl/chained_hash_id_map.sv -----
// ----------------------------------------------------------------------------
// chained_hash_id_map
// Key-to-value map: bucket head table plus a pool of chained slots.
// ----------------------------------------------------------------------------
// One item at a time. An accepted item reads the bucket head (S_HEAD,
// S_HWAIT), then walks the chain; each chain entry takes a slot memory
// read (S_SREAD), then a compare (S_SCMP). A lookup that hits, and a lookup
// or remove that misses, go to S_OUT; a replace or a remove that hits passes
// through S_WRITE first. An insert of a new key picks a slot in S_FREE: a
// never-used slot goes straight to S_WRITE, a slot from the free list
// passes through S_FWAIT first, and a refusal goes to S_OUT. An unused
// action code skips the walk and posts its result from the idle state. The
// single-port slot memory read sets the walk rate. After reset a clearing
// pass empties the bucket table; no item is accepted during it. The result
// is held in an output register until taken, and no new item is accepted
// while it waits.
module chained_hash_id_map (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic [1:0]                action,
    input  logic [63:0]               key,
    input  logic [63:0]               raw_hash,
    input  logic [31:0]               new_value,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic                      found,
    output logic [31:0]               value_out,
    output logic                      pool_full,
    output logic [8:0]                entry_count
);
    import chm_pkg::*;

    localparam logic [3:0] S_CLEAR = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_HEAD  = 4'd2;
    localparam logic [3:0] S_HWAIT = 4'd3;
    localparam logic [3:0] S_SREAD = 4'd4;
    localparam logic [3:0] S_SCMP  = 4'd5;
    localparam logic [3:0] S_FREE  = 4'd6;
    localparam logic [3:0] S_FWAIT = 4'd7;
    localparam logic [3:0] S_WRITE = 4'd8;
    localparam logic [3:0] S_OUT   = 4'd9;

    logic [IDX_W-1:0]  head_mem [NBUCKETS];
    logic [KEY_W-1:0]  key_mem  [POOL_ENTRIES];
    logic [VAL_W-1:0]  val_mem  [POOL_ENTRIES];
    logic [IDX_W-1:0]  next_mem [POOL_ENTRIES];

    logic [3:0]             state_reg;
    logic [TABLE_BITS:0]    clr_reg;
    action_t                act_reg;
    logic [KEY_W-1:0]       key_reg;
    logic [VAL_W-1:0]       nval_reg;
    logic [TABLE_BITS-1:0]  bkt_reg;
    logic [IDX_W-1:0]       cur_reg, prev_reg, head_reg, nidx_reg;
    logic [IDX_W-1:0]       free_head_reg, unused_reg;
    logic [CNT_W-1:0]       live_reg;
    logic [IDX_W:0]         steps_reg;
    logic                   hit_reg;

    logic [IDX_W-1:0]       head_rd;
    logic [KEY_W-1:0]       key_rd;
    logic [VAL_W-1:0]       val_rd;
    logic [IDX_W-1:0]       next_rd;
    logic [SLOT_W-1:0]      slot_addr;

    logic                   ov_reg, fnd_reg, full_reg;
    logic [VAL_W-1:0]       vout_reg;

    assign in_stall    = (state_reg != S_IDLE) || ov_reg;
    assign out_valid   = ov_reg;
    assign found       = fnd_reg;
    assign value_out   = vout_reg;
    assign pool_full   = full_reg;
    assign entry_count = live_reg;

    // head memory: read of bkt_reg, writes on clear and on link/unlink
    logic                   hw_en;
    logic [TABLE_BITS-1:0]  hw_addr;
    logic [IDX_W-1:0]       hw_data;
    always_ff @(posedge clk)
    begin
        if (hw_en)
            head_mem[hw_addr] <= hw_data;
        head_rd <= head_mem[bkt_reg];
    end

    // slot memories share one address
    logic sk_we, sv_we, sn_we;
    logic [IDX_W-1:0] sn_data;
    always_ff @(posedge clk)
    begin
        if (sk_we) key_mem[slot_addr]  <= key_reg;
        if (sv_we) val_mem[slot_addr]  <= nval_reg;
        if (sn_we) next_mem[slot_addr] <= sn_data;
        key_rd  <= key_mem[slot_addr];
        val_rd  <= val_mem[slot_addr];
        next_rd <= next_mem[slot_addr];
    end

    logic is_ins, is_rem;
    assign is_ins = (act_reg == ACT_INSERT);
    assign is_rem = (act_reg == ACT_REMOVE);

    always_comb
    begin
        hw_en     = 1'b0;
        hw_addr   = bkt_reg;
        hw_data   = NULL_IDX;
        sk_we     = 1'b0;
        sv_we     = 1'b0;
        sn_we     = 1'b0;
        sn_data   = head_reg;
        slot_addr = cur_reg[SLOT_W-1:0];
        unique case (state_reg)
            S_CLEAR:
            begin
                hw_en   = 1'b1;
                hw_addr = clr_reg[TABLE_BITS-1:0];
            end
            S_FREE: slot_addr = free_head_reg[SLOT_W-1:0];
            S_WRITE:
            begin
                if (is_ins && hit_reg)
                begin
                    sv_we = 1'b1;
                end
                else if (is_ins)
                begin
                    slot_addr = nidx_reg[SLOT_W-1:0];
                    sk_we = 1'b1; sv_we = 1'b1; sn_we = 1'b1;
                    sn_data = head_reg;
                    hw_en = 1'b1; hw_data = nidx_reg;
                end
                else
                begin
                    // remove, in S_WRITE: link predecessor past cur
                    if (prev_reg == NULL_IDX)
                    begin
                        hw_en = 1'b1; hw_data = next_rd;
                    end
                    else
                    begin
                        slot_addr = prev_reg[SLOT_W-1:0];
                        sn_we = 1'b1; sn_data = next_rd;
                    end
                end
            end
            S_OUT:
            begin
                if (is_rem && hit_reg)
                begin
                    sn_we = 1'b1; sn_data = free_head_reg;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            free_head_reg <= NULL_IDX;
            unused_reg    <= IDX_W'(POOL_ENTRIES);
            live_reg      <= '0;
            ov_reg        <= 1'b0;
        end
        else
        begin
            if (ov_reg && !out_stall)
                ov_reg <= 1'b0;
            unique case (state_reg)
                S_CLEAR:
                begin
                    clr_reg <= clr_reg + 1'b1;
                    if (clr_reg == (TABLE_BITS+1)'(NBUCKETS - 1))
                        state_reg <= S_IDLE;
                end
                S_IDLE:
                begin
                    if (in_valid && !ov_reg)
                    begin
                        act_reg  <= action;
                        key_reg  <= key;
                        nval_reg <= new_value;
                        bkt_reg  <= mix_bucket(raw_hash);
                        hit_reg  <= 1'b0;
                        prev_reg <= NULL_IDX;
                        steps_reg <= '0;
                        vout_reg <= '0;
                        full_reg <= 1'b0;
                        if (action == ACT_INSERT || action == ACT_LOOKUP ||
                            action == ACT_REMOVE)
                            state_reg <= S_HEAD;
                        else
                        begin
                            fnd_reg <= 1'b0;
                            ov_reg  <= 1'b1;
                        end
                    end
                end
                S_HEAD:  state_reg <= S_HWAIT;
                S_HWAIT:
                begin
                    head_reg <= head_rd;
                    cur_reg  <= head_rd;
                    state_reg <= S_SREAD;
                end
                S_SREAD:
                begin
                    if (cur_reg >= NULL_IDX ||
                        steps_reg >= (IDX_W+1)'(POOL_ENTRIES))
                        state_reg <= (is_ins) ? S_FREE : S_OUT;
                    else
                        state_reg <= S_SCMP;
                end
                S_SCMP:
                begin
                    if (key_rd == key_reg)
                    begin
                        hit_reg   <= 1'b1;
                        vout_reg  <= val_rd;
                        state_reg <= (act_reg == ACT_LOOKUP) ? S_OUT : S_WRITE;
                    end
                    else
                    begin
                        prev_reg  <= cur_reg;
                        cur_reg   <= next_rd;
                        steps_reg <= steps_reg + 1'b1;
                        state_reg <= S_SREAD;
                    end
                end
                S_FREE:
                begin
                    if (free_head_reg < NULL_IDX)
                    begin
                        nidx_reg  <= free_head_reg;
                        state_reg <= S_FWAIT;
                    end
                    else if (unused_reg != '0)
                    begin
                        nidx_reg   <= IDX_W'(POOL_ENTRIES) - unused_reg;
                        unused_reg <= unused_reg - 1'b1;
                        live_reg   <= live_reg + 1'b1;
                        state_reg  <= S_WRITE;
                    end
                    else
                    begin
                        full_reg  <= 1'b1;
                        state_reg <= S_OUT;
                    end
                end
                S_FWAIT:
                begin
                    free_head_reg <= next_rd;
                    live_reg      <= live_reg + 1'b1;
                    state_reg     <= S_WRITE;
                end
                S_WRITE:
                begin
                    state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    if (is_rem && hit_reg)
                    begin
                        free_head_reg <= cur_reg;
                        if (live_reg != '0)
                            live_reg <= live_reg - 1'b1;
                    end
                    fnd_reg   <= hit_reg;
                    ov_reg    <= 1'b1;
                    state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule

// ----- hw/rtl/chm_checker.sv -----
// ----------------------------------------------------------------------------
// chm_checker
// Port-level checks for the chained hash id map.
// ----------------------------------------------------------------------------
module chm_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic [1:0]  action,
    input logic        out_valid,
    input logic        out_stall,
    input logic        found,
    input logic        pool_full,
    input logic [8:0]  entry_count
);
    import chm_pkg::*;

    // no item accepted while a result waits
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall)
        else $error("item accepted with result pending");

    a_full_not_found: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(found && pool_full))
        else $error("found and pool_full together");

    a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> entry_count <= 9'(POOL_ENTRIES))
        else $error("entry count over pool size");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(entry_count))
        else $error("stalled result changed");

    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_stall |=> in_valid && $stable(action))
        else $error("stalled input item changed");
endmodule

bind chained_hash_id_map chm_checker u_chm_checker (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .action(action), .out_valid(out_valid), .out_stall(out_stall),
    .found(found), .pool_full(pool_full), .entry_count(entry_count)
);

// ----- tb/sv/chained_hash_id_map_test.sv -----
// ----------------------------------------------------------------------------
// chained_hash_id_map_test
// Drives insert, lookup, remove and unused action items into the hash map,
// models the bucket chains and slot pool in the bench, and checks every result field in order.
// ----------------------------------------------------------------------------
module chained_hash_id_map_test;
    import chm_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int HOLD_CYCLES = 300;
    localparam action_t ACT_UNUSED = 2'd3;

    typedef struct packed {
        action_t     action;
        logic [63:0] key;
        logic [63:0] raw_hash;
        logic [31:0] new_value;
    } map_op_t;

    typedef struct packed {
        logic        found;
        logic [31:0] value_out;
        logic        pool_full;
        logic [8:0]  entry_count;
    } map_reply_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [1:0]  action;
    logic [63:0] key;
    logic [63:0] raw_hash;
    logic [31:0] new_value;
    logic        out_valid;
    logic        out_stall;
    logic        found;
    logic [31:0] value_out;
    logic        pool_full;
    logic [8:0]  entry_count;

    chained_hash_id_map dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .action      (action),
        .key         (key),
        .raw_hash    (raw_hash),
        .new_value   (new_value),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .found       (found),
        .value_out   (value_out),
        .pool_full   (pool_full),
        .entry_count (entry_count)
    );

    // bench copy of the map
    int unsigned bucket_first [NBUCKETS];
    logic [63:0] entry_key    [POOL_ENTRIES];
    logic [31:0] entry_value  [POOL_ENTRIES];
    int unsigned entry_link   [POOL_ENTRIES];
    int unsigned free_first;
    int unsigned fresh_left;
    int unsigned held_count;

    map_op_t    pending_ops[$];
    map_reply_t expected_replies[$];
    int unsigned error_count;
    int unsigned idle_cycles;
    int unsigned hold_left;
    bit          calm_phase;
    bit          hold_receiver;

    // live keys for well-formed random traffic
    logic [63:0] live_keys[$];
    logic [63:0] live_hashes[$];

    always #5 clk = ~clk;

    function automatic int unsigned bucket_of(logic [63:0] h);
        logic [63:0] m;
        begin
            m = (h << 7) - h + (h >> 9) + (h >> 17);
            return int'(m[TABLE_BITS-1:0]);
        end
    endfunction

    function automatic map_reply_t apply_map_op(map_op_t op);
        map_reply_t  r;
        int unsigned b;
        int unsigned cur;
        int unsigned prev;
        int unsigned hit;
        int unsigned steps;
        int unsigned n;
        begin
            r = '0;
            b = bucket_of(op.raw_hash);
            hit = POOL_ENTRIES;
            prev = POOL_ENTRIES;
            if (op.action != ACT_UNUSED)
            begin
                cur = bucket_first[b];
                steps = 0;
                while (cur < POOL_ENTRIES && steps < POOL_ENTRIES && hit == POOL_ENTRIES)
                begin
                    if (entry_key[cur] == op.key)
                        hit = cur;
                    else
                    begin
                        prev = cur;
                        cur = entry_link[cur];
                    end
                    steps++;
                end
                if (hit == POOL_ENTRIES)
                    prev = POOL_ENTRIES;
                else
                begin
                    r.found = 1'b1;
                    r.value_out = entry_value[hit];
                end
                if (op.action == ACT_INSERT)
                begin
                    if (hit < POOL_ENTRIES)
                        entry_value[hit] = op.new_value;
                    else
                    begin
                        n = POOL_ENTRIES;
                        if (free_first < POOL_ENTRIES)
                        begin
                            n = free_first;
                            free_first = entry_link[n];
                        end
                        else if (fresh_left > 0)
                        begin
                            n = POOL_ENTRIES - fresh_left;
                            fresh_left--;
                        end
                        if (n < POOL_ENTRIES)
                        begin
                            entry_key[n] = op.key;
                            entry_value[n] = op.new_value;
                            entry_link[n] = bucket_first[b];
                            bucket_first[b] = n;
                            held_count++;
                        end
                        else
                            r.pool_full = 1'b1;
                    end
                end
                else if (op.action == ACT_REMOVE && hit < POOL_ENTRIES)
                begin
                    if (prev < POOL_ENTRIES)
                        entry_link[prev] = entry_link[hit];
                    else
                        bucket_first[b] = entry_link[hit];
                    entry_link[hit] = free_first;
                    free_first = hit;
                    if (held_count > 0)
                        held_count--;
                end
            end
            r.entry_count = held_count[8:0];
            return r;
        end
    endfunction

    task automatic queue_op(action_t a, logic [63:0] k, logic [63:0] h, logic [31:0] v);
        map_op_t op;
        begin
            op.action = a;
            op.key = k;
            op.raw_hash = h;
            op.new_value = v;
            pending_ops.push_back(op);
        end
    endtask

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        begin
            $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
            error_count++;
        end
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    // driver; accepted items are predicted at the edge they are taken
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            action <= '0;
            key <= '0;
            raw_hash <= '0;
            new_value <= '0;
        end
        else
        begin
            if (in_valid && !in_stall)
                expected_replies.push_back(apply_map_op(pending_ops.pop_front()));
            if (in_valid && in_stall)
                ;
            else if (pending_ops.size() > 0 &&
                     (calm_phase || $urandom_range(99) >= 23))
            begin
                in_valid <= 1'b1;
                action <= pending_ops[0].action;
                key <= pending_ops[0].key;
                raw_hash <= pending_ops[0].raw_hash;
                new_value <= pending_ops[0].new_value;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // receiver stall; a hold request starts a counted stretch of stalls
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b1;
            hold_left <= 0;
        end
        else if (hold_receiver)
        begin
            out_stall <= 1'b1;
            hold_left <= HOLD_CYCLES;
        end
        else if (hold_left != 0)
        begin
            out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end
        else
            out_stall <= !calm_phase && ($urandom_range(99) < 23);
    end

    // monitor
    always @(posedge clk)
    begin
        map_reply_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_replies.size() == 0)
                report_mismatch("unexpected result", 64'(entry_count), 64'd0);
            else
            begin
                want = expected_replies.pop_front();
                if (found !== want.found)
                    report_mismatch("found", 64'(found), 64'(want.found));
                if (value_out !== want.value_out)
                    report_mismatch("value_out", 64'(value_out), 64'(want.value_out));
                if (pool_full !== want.pool_full)
                    report_mismatch("pool_full", 64'(pool_full), 64'(want.pool_full));
                if (entry_count !== want.entry_count)
                    report_mismatch("entry_count", 64'(entry_count),
                                    64'(want.entry_count));
            end
        end
    end

    // watchdog: cycles with nothing accepted on either side
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    task automatic wait_drained();
        begin
            while (pending_ops.size() != 0 || expected_replies.size() != 0)
                @(posedge clk);
        end
    endtask

    initial
    begin
        int unsigned i;
        int unsigned pick;
        int unsigned roll;
        logic [63:0] k;
        logic [63:0] h;
        clk = 1'b0;
        rst_n = 1'b0;
        error_count = 0;
        idle_cycles = 0;
        calm_phase = 1'b0;
        hold_receiver = 1'b0;
        for (i = 0; i < NBUCKETS; i++)
            bucket_first[i] = POOL_ENTRIES;
        for (i = 0; i < POOL_ENTRIES; i++)
        begin
            entry_key[i] = '0;
            entry_value[i] = '0;
            entry_link[i] = 0;
        end
        free_first = POOL_ENTRIES;
        fresh_left = POOL_ENTRIES;
        held_count = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // directed: empty map, extremes, collisions, replace, remove
        queue_op(ACT_LOOKUP, '0, '0, '0);
        queue_op(ACT_REMOVE, '1, '1, '1);
        queue_op(ACT_INSERT, '0, '0, '1);
        queue_op(ACT_INSERT, '1, '1, 32'h0);
        queue_op(ACT_INSERT, '0, '0, 32'h1234_5678);
        queue_op(ACT_LOOKUP, '0, '0, '0);
        queue_op(ACT_LOOKUP, '1, '1, '1);
        // same key, other bucket counts as a new key
        queue_op(ACT_LOOKUP, '0, 64'd1, '0);
        queue_op(ACT_INSERT, '0, 64'd1, 32'hA5A5_A5A5);
        // chain of three in one bucket (same raw hash), remove the middle one
        queue_op(ACT_INSERT, 64'd10, 64'h55, 32'd10);
        queue_op(ACT_INSERT, 64'd11, 64'h55, 32'd11);
        queue_op(ACT_INSERT, 64'd12, 64'h55, 32'd12);
        queue_op(ACT_REMOVE, 64'd11, 64'h55, '0);
        queue_op(ACT_LOOKUP, 64'd10, 64'h55, '0);
        queue_op(ACT_LOOKUP, 64'd12, 64'h55, '0);
        queue_op(ACT_REMOVE, 64'd12, 64'h55, '0);
        queue_op(ACT_REMOVE, 64'd10, 64'h55, '0);
        queue_op(ACT_UNUSED, '1, '1, '1);
        queue_op(ACT_INSERT, 64'd13, 64'h55, 32'd13);
        wait_drained();

        // receiver held off while the sender keeps offering
        hold_receiver = 1'b1;
        for (i = 0; i < 40; i++)
            queue_op(action_t'($urandom_range(2)), 64'($urandom_range(7)),
                     64'($urandom_range(3)), $urandom());
        wait (hold_left != 0);
        hold_receiver = 1'b0;
        wait_drained();

        // fill the pool to exhaustion, then refusals, then drain some
        calm_phase = 1'b1;
        for (i = 0; i < POOL_ENTRIES + 6; i++)
        begin
            k = rand64();
            h = rand64();
            queue_op(ACT_INSERT, k, h, $urandom());
            live_keys.push_back(k);
            live_hashes.push_back(h);
        end
        queue_op(ACT_INSERT, live_keys[3], live_hashes[3], $urandom());
        wait_drained();
        calm_phase = 1'b0;
        for (i = 0; i < 60; i++)
        begin
            pick = $urandom_range(live_keys.size() - 1);
            queue_op(ACT_REMOVE, live_keys[pick], live_hashes[pick], $urandom());
            live_keys.delete(pick);
            live_hashes.delete(pick);
        end
        wait_drained();

        // random mix; mostly keys from a small set so chains and hits happen
        for (i = 0; i < 1300; i++)
        begin
            roll = $urandom_range(99);
            if (roll < 70)
            begin
                k = 64'($urandom_range(40));
                h = 64'($urandom_range(15)) << ($urandom_range(1) * 20);
            end
            else if (roll < 85 && live_keys.size() > 0)
            begin
                pick = $urandom_range(live_keys.size() - 1);
                k = live_keys[pick];
                h = live_hashes[pick];
            end
            else
            begin
                k = rand64();
                h = rand64();
            end
            roll = $urandom_range(99);
            queue_op(roll < 40 ? ACT_INSERT : roll < 70 ? ACT_LOOKUP :
                     roll < 97 ? ACT_REMOVE : ACT_UNUSED, k, h, $urandom());
            if (i == 600)
            begin
                wait_drained();
                calm_phase = 1'b1;
            end
            if (i == 800)
            begin
                wait_drained();
                calm_phase = 1'b0;
            end
        end
        wait_drained();
        repeat (50) @(posedge clk);
        if (error_count == 0 && expected_replies.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end
endmodule

// ----- files.f -----
hw/rtl/chm_pkg.sv
hw/rtl/chained_hash_id_map.sv
hw/rtl/chm_checker.sv
tb/sv/chained_hash_id_map_test.sv
